// ===== design/intel_hex_record_loader_macros.svh =====
// assertion macros for the intel hex record loader
`ifndef INTEL_HEX_RECORD_LOADER_MACROS_SVH
`define INTEL_HEX_RECORD_LOADER_MACROS_SVH

`ifndef SYNTHESIS

// condition in the same cycle implies consequence
`define IHEX_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the following cycle
`define IHEX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define IHEX_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define IHEX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/ihex_pkg.sv =====
// shared types, codes and helpers for the intel hex record loader
`default_nettype none

package ihex_pkg;

  localparam int ADDR_WIDTH_DEFAULT = 16;
  localparam int CNT_W = 16;
  localparam int OUT_ADDR_W = 16;

  // parser phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_COUNT = 3'd1,
    PH_ADHI  = 3'd2,
    PH_ADLO  = 3'd3,
    PH_TYPE  = 3'd4,
    PH_DATA  = 3'd5,
    PH_CSUM  = 3'd6
  } phase_t;

  // result kinds
  localparam logic [2:0] KIND_WRITE   = 3'd0;
  localparam logic [2:0] KIND_GOOD    = 3'd1;
  localparam logic [2:0] KIND_BAD     = 3'd2;
  localparam logic [2:0] KIND_FORMAT  = 3'd3;
  localparam logic [2:0] KIND_ENDGOOD = 3'd4;
  localparam logic [2:0] KIND_ENDBAD  = 3'd5;

  // record types
  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_END  = 8'h01;

  localparam logic [7:0] CHAR_COLON = 8'h3A;

  typedef struct packed {
    logic                  valid;
    logic [2:0]            kind;
    logic [OUT_ADDR_W-1:0] addr;
    logic [7:0]            data;
    logic [CNT_W-1:0]      bytes_total;
    logic [CNT_W-1:0]      record_number;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  // ascii hex digit decode, either case
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.ok = 1'b0;
    d.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.ok = 1'b1;
      d.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.ok = 1'b1;
      d.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.ok = 1'b1;
      d.value = 4'(c - 8'h57);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== design/ihex_char_if.sv =====
// character input channel
`default_nettype none

interface ihex_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

`default_nettype wire

// ===== design/ihex_res_if.sv =====
// result output channel
`default_nettype none

interface ihex_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [15:0] write_address;
  logic [7:0]  write_data;
  logic [15:0] bytes_total;
  logic [15:0] record_number;

  modport source (output valid, output result_kind, output write_address,
                  output write_data, output bytes_total, output record_number,
                  input ready);
  modport sink (input valid, input result_kind, input write_address,
                input write_data, input bytes_total, input record_number,
                output ready);
endinterface

`default_nettype wire

// ===== design/ihex_parser.sv =====
// record parse state and single-character step logic
`default_nettype none

`include "intel_hex_record_loader_macros.svh"

module ihex_parser #(
  parameter int ADDR_WIDTH = ihex_pkg::ADDR_WIDTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire logic [7:0]    char_in,
  output ihex_pkg::res_t     res
);
  import ihex_pkg::*;

  phase_t                phase, phase_next;
  logic [3:0]            high_nibble, high_nibble_next;
  logic                  nibble_pending, nibble_pending_next;
  logic [7:0]            record_length, record_length_next;
  logic [ADDR_WIDTH-1:0] load_address, load_address_next;
  logic [7:0]            record_kind, record_kind_next;
  logic [7:0]            running_sum, running_sum_next;
  logic [7:0]            bytes_left, bytes_left_next;
  logic [CNT_W-1:0]      byte_counter, byte_counter_next;
  logic [CNT_W-1:0]      record_counter, record_counter_next;
  logic                  finished, finished_next;

  hex_digit_t digit;
  logic [7:0] byte_val;
  logic [7:0] left_dec;

  assign digit    = hex_decode(char_in);
  assign byte_val = {high_nibble, digit.value};
  assign left_dec = bytes_left - 8'd1;

  // next state and result for the current character
  always_comb begin
    phase_next          = phase;
    high_nibble_next    = high_nibble;
    nibble_pending_next = nibble_pending;
    record_length_next  = record_length;
    load_address_next   = load_address;
    record_kind_next    = record_kind;
    running_sum_next    = running_sum;
    bytes_left_next     = bytes_left;
    byte_counter_next   = byte_counter;
    record_counter_next = record_counter;
    finished_next       = finished;
    res.valid = 1'b0;
    res.kind  = KIND_WRITE;
    res.addr  = '0;
    res.data  = '0;

    if (finished) begin
      // everything ignored after an end record
    end else if (phase == PH_IDLE) begin
      if (char_in == CHAR_COLON) begin
        record_counter_next = record_counter + 16'd1;
        running_sum_next    = 8'd0;
        nibble_pending_next = 1'b0;
        high_nibble_next    = 4'd0;
        phase_next          = PH_COUNT;
      end
    end else if (!digit.ok) begin
      phase_next          = PH_IDLE;
      nibble_pending_next = 1'b0;
      res.valid           = 1'b1;
      res.kind            = KIND_FORMAT;
    end else if (!nibble_pending) begin
      high_nibble_next    = digit.value;
      nibble_pending_next = 1'b1;
    end else begin
      nibble_pending_next = 1'b0;
      running_sum_next    = running_sum + byte_val;
      unique case (phase)
        PH_COUNT: begin
          record_length_next = byte_val;
          phase_next         = PH_ADHI;
        end
        PH_ADHI: begin
          load_address_next = ADDR_WIDTH'({byte_val, 8'h00});
          phase_next        = PH_ADLO;
        end
        PH_ADLO: begin
          load_address_next = load_address | ADDR_WIDTH'(byte_val);
          phase_next        = PH_TYPE;
        end
        PH_TYPE: begin
          record_kind_next = byte_val;
          if (byte_val == REC_DATA) begin
            bytes_left_next = record_length;
            phase_next      = (record_length == 8'd0) ? PH_CSUM : PH_DATA;
          end else if (byte_val == REC_END) begin
            phase_next = PH_CSUM;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_DATA: begin
          load_address_next = load_address + ADDR_WIDTH'(1);
          byte_counter_next = byte_counter + 16'd1;
          bytes_left_next   = left_dec;
          if (left_dec == 8'd0) begin
            phase_next = PH_CSUM;
          end
          res.valid = 1'b1;
          res.kind  = KIND_WRITE;
          res.addr  = load_address[OUT_ADDR_W-1:0];
          res.data  = byte_val;
        end
        PH_CSUM: begin
          phase_next = PH_IDLE;
          res.valid  = 1'b1;
          if (record_kind == REC_END) begin
            finished_next = 1'b1;
            res.kind = (running_sum_next == 8'd0) ? KIND_ENDGOOD : KIND_ENDBAD;
          end else begin
            res.kind = (running_sum_next == 8'd0) ? KIND_GOOD : KIND_BAD;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
    res.bytes_total   = byte_counter_next;
    res.record_number = record_counter_next;
  end

  // state registers, updated on each character transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      high_nibble    <= 4'd0;
      nibble_pending <= 1'b0;
      record_length  <= 8'd0;
      load_address   <= '0;
      record_kind    <= 8'd0;
      running_sum    <= 8'd0;
      bytes_left     <= 8'd0;
      byte_counter   <= '0;
      record_counter <= '0;
      finished       <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      high_nibble    <= high_nibble_next;
      nibble_pending <= nibble_pending_next;
      record_length  <= record_length_next;
      load_address   <= load_address_next;
      record_kind    <= record_kind_next;
      running_sum    <= running_sum_next;
      bytes_left     <= bytes_left_next;
      byte_counter   <= byte_counter_next;
      record_counter <= record_counter_next;
      finished       <= finished_next;
    end
  end

  // checks
  `IHEX_ASSERT_NOW(a_quiet_after_end, clk, rst, finished, !res.valid,
    "result produced after end record")
  `IHEX_ASSERT_NOW(a_quiet_outside_record, clk, rst, phase == PH_IDLE, !res.valid,
    "result produced outside a record")
  `IHEX_ASSERT_NEXT(a_write_counts, clk, rst,
    advance && res.valid && res.kind == KIND_WRITE,
    byte_counter == $past(byte_counter) + 16'd1,
    "byte total did not follow a write")
  `IHEX_ASSERT_NEXT(a_end_stops, clk, rst,
    advance && res.valid && (res.kind == KIND_ENDGOOD || res.kind == KIND_ENDBAD),
    finished,
    "end record did not stop the parser")

endmodule

`default_nettype wire

// ===== design/intel_hex_record_loader.sv =====
// top level of the intel hex record loader
`default_nettype none

// Intel HEX record loader: takes one ASCII character per transfer on char_ch
// and reports data writes and per-record status on res_ch. A character can be
// taken on every clock; each one passes an input register and a single parse
// step, and its result (if any) is then shown from a result register. The
// parse step on the registered character sets the rate of one character per
// cycle; a stalled result register holds the next character in the input
// register until the result is taken. After an end record all input is taken
// and dropped until reset.

module intel_hex_record_loader #(
  parameter int ADDR_WIDTH = ihex_pkg::ADDR_WIDTH_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  ihex_char_if.sink char_ch,
  ihex_res_if.source res_ch
);
  import ihex_pkg::*;

  logic       in_valid;
  logic [7:0] in_char;
  logic       advance;
  res_t       step_res;
  logic       out_valid;
  res_t       out_res;

  // input stage moves when the result register can take its result
  assign advance       = in_valid && (!out_valid || res_ch.ready);
  assign char_ch.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (char_ch.ready) begin
      in_valid <= char_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ch.ready && char_ch.valid) begin
      in_char <= char_ch.char_in;
    end
  end

  ihex_parser #(
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .char_in (in_char),
    .res     (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step_res.valid) begin
      out_valid <= 1'b1;
    end else if (res_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      out_res <= step_res;
    end
  end

  assign res_ch.valid         = out_valid;
  assign res_ch.result_kind   = out_res.kind;
  assign res_ch.write_address = out_res.addr;
  assign res_ch.write_data    = out_res.data;
  assign res_ch.bytes_total   = out_res.bytes_total;
  assign res_ch.record_number = out_res.record_number;

endmodule

`default_nettype wire
